@@ rtl/sitc_pkg.sv @@
// shared types, widths and the square-root digit step for the spiral coordinate block
package sitc_pkg;

  localparam int POS_W  = 32;
  localparam int SIDE_W = 16;
  localparam int ROOT_W = 16;
  localparam int REM_W  = 18;
  localparam int D_W    = 18;

  // per-item flags that ride alongside the root pipeline
  typedef struct packed {
    logic              one;
    logic              bad;
    logic              pos_one;
    logic [SIDE_W-1:0] c1;
  } tag_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_acc_t;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_LEFT,
    SIDE_BOTTOM,
    SIDE_RIGHT
  } ring_side_t;

  // one result bit of a restoring integer square root
  function automatic root_acc_t root_step(input root_acc_t acc, input logic [1:0] pair);
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    root_acc_t        res;
    cand  = {acc.rem[REM_W-3:0], pair};
    trial = {acc.root, 2'b01};
    if (cand >= trial) begin
      res.rem  = cand - trial;
      res.root = {acc.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cand;
      res.root = {acc.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ rtl/sitc_root_pipe.sv @@
// pipelined integer square root, one result bit per stage, with a flag sideband
module sitc_root_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sitc_pkg::POS_W-1:0]    in_x,
  input  sitc_pkg::tag_t                in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sitc_pkg::ROOT_W-1:0]   out_root,
  output logic [sitc_pkg::REM_W-1:0]    out_rem,
  output sitc_pkg::tag_t                out_tag
);

  localparam int N = sitc_pkg::ROOT_W;

  logic                       vld   [N];
  logic                       adv   [N+1];
  logic [sitc_pkg::POS_W-1:0] x_q   [N];
  sitc_pkg::root_acc_t        acc_q [N];
  sitc_pkg::tag_t             tag_q [N];

  assign adv[N] = out_ready;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [sitc_pkg::POS_W-1:0] x_in;
    sitc_pkg::root_acc_t        acc_in;
    sitc_pkg::tag_t             tag_in;
    logic                       v_in;

    if (i == 0) begin : g_first
      assign x_in   = in_x;
      assign acc_in = '0;
      assign tag_in = in_tag;
      assign v_in   = in_valid;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign acc_in = acc_q[i-1];
      assign tag_in = tag_q[i-1];
      assign v_in   = vld[i-1];
    end

    // a stage takes a new beat when it is empty or its successor moves
    assign adv[i] = !vld[i] || adv[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv[i]) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i] && v_in) begin
        x_q[i]   <= x_in;
        acc_q[i] <= sitc_pkg::root_step(acc_in, x_in[sitc_pkg::POS_W-2-2*i +: 2]);
        tag_q[i] <= tag_in;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[N-1];
  assign out_root  = acc_q[N-1].root;
  assign out_rem   = acc_q[N-1].rem;
  assign out_tag   = tag_q[N-1];

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rem <= {1'b0, out_root, 1'b0})
    else $error("root remainder exceeds twice the root");

  a_first_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted beat missing from first root stage");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_root) && $stable(out_rem))
    else $error("stalled root beat changed or dropped");
`endif

endmodule

@@ rtl/spiral_index_to_coordinate_top.sv @@
// top level: spiral position to line and column, fully pipelined
//
// Usage:
//   grid_side is written through cfg_wr_en / cfg_wr_data while no beat is in
//   flight; it resets to 1, which maps every position to line 1, column 1.
//   Positions enter on in_valid / in_ready, one beat per cycle while out_ready is high.
//   Each beat yields exactly one result beat on out_valid / out_ready with
//   line, column and position_bad, in input order.
//   Stages in order: one entry stage that squares the side, sixteen
//   square-root stages (one root bit each), then ring offset, side select
//   and the output register.
//   Throughput is one beat per cycle while out_ready stays high.
//   Every stage has its own valid bit; when out_ready is low the pipeline
//   holds, empty stages still fill, and in_ready drops once the stage behind
//   the input is full, so nothing is lost or repeated.
//   Reset clears all valid bits and sets grid_side to 1.
//   A bad beat (even side, zero position, position past side squared)
//   returns line 0, column 0 with position_bad set, unless the side is 1.
module spiral_index_to_coordinate_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sitc_pkg::SIDE_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sitc_pkg::POS_W-1:0]    position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sitc_pkg::SIDE_W-1:0]   line,
  output logic [sitc_pkg::SIDE_W-1:0]   column,
  output logic                          position_bad
);

  localparam int SW = sitc_pkg::SIDE_W;
  localparam int DW = sitc_pkg::D_W;

  logic [SW-1:0] grid_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= SW'(1);
    end else if (cfg_wr_en) begin
      grid_side <= cfg_wr_data;
    end
  end

  // entry stage: latch position, square the side
  logic                       v0;
  logic [sitc_pkg::POS_W-1:0] p_q;
  logic [sitc_pkg::POS_W-1:0] nsq_q;
  logic                       one_q;
  logic                       even_q;
  logic [SW-1:0]              c1_q;
  logic [sitc_pkg::POS_W-1:0] nsq_next;
  logic                       adv0;
  logic                       rp_in_ready;

  assign nsq_next = sitc_pkg::POS_W'(grid_side) * sitc_pkg::POS_W'(grid_side);
  assign adv0     = !v0 || rp_in_ready;
  assign in_ready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      p_q    <= position;
      nsq_q  <= nsq_next;
      one_q  <= (grid_side == SW'(1));
      even_q <= !grid_side[0];
      c1_q   <= {1'b0, grid_side[SW-1:1]} + SW'(1);
    end
  end

  sitc_pkg::tag_t             tag0;
  logic [sitc_pkg::POS_W-1:0] x0;

  assign tag0.one     = one_q;
  assign tag0.bad     = even_q || (p_q == '0) || (p_q > nsq_q);
  assign tag0.pos_one = (p_q == sitc_pkg::POS_W'(1));
  assign tag0.c1      = c1_q;
  assign x0           = p_q - sitc_pkg::POS_W'(1);

  logic                        rp_out_valid;
  logic                        advd;
  logic [sitc_pkg::ROOT_W-1:0] rp_root;
  logic [sitc_pkg::REM_W-1:0]  rp_rem;
  sitc_pkg::tag_t              rp_tag;

  sitc_root_pipe u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (rp_in_ready),
    .in_x      (x0),
    .in_tag    (tag0),
    .out_valid (rp_out_valid),
    .out_ready (advd),
    .out_root  (rp_root),
    .out_rem   (rp_rem),
    .out_tag   (rp_tag)
  );

  // ring stage: odd root m, ring k, offset d past m*m
  logic           vd;
  logic [DW-1:0]  d_q;
  logic [SW-1:0]  k_q;
  sitc_pkg::tag_t tag_d;
  logic [DW-1:0]  d_next;
  logic [SW-1:0]  k_next;
  logic           adve;

  always_comb begin
    if (rp_root[0]) begin
      d_next = DW'(rp_rem) + DW'(1);
      k_next = {1'b0, rp_root[SW-1:1]} + SW'(1);
    end else begin
      // root even: step down to the odd value below it
      d_next = DW'(rp_rem) + DW'({rp_root, 1'b0});
      k_next = {1'b0, rp_root[SW-1:1]};
    end
  end

  assign advd = !vd || adve;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (advd) begin
      vd <= rp_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advd && rp_out_valid) begin
      d_q   <= d_next;
      k_q   <= k_next;
      tag_d <= rp_tag;
    end
  end

  // side stage: which side of the ring, plus multiples of k
  logic                 ve;
  sitc_pkg::ring_side_t side_q;
  sitc_pkg::ring_side_t side_next;
  logic [SW-1:0]        d16_q;
  logic [SW-1:0]        k_e;
  logic [SW-1:0]        k3_q;
  logic [SW-1:0]        k5_q;
  logic [SW-1:0]        k7_q;
  sitc_pkg::tag_t       tag_e;
  logic [DW-1:0]        two_k;
  logic [DW-1:0]        four_k;
  logic [DW-1:0]        six_k;
  logic                 advf;

  assign two_k  = DW'({k_q, 1'b0});
  assign four_k = DW'({k_q, 2'b00});
  assign six_k  = four_k + two_k;

  always_comb begin
    if (d_q <= two_k) begin
      side_next = sitc_pkg::SIDE_TOP;
    end else if (d_q <= four_k) begin
      side_next = sitc_pkg::SIDE_LEFT;
    end else if (d_q <= six_k) begin
      side_next = sitc_pkg::SIDE_BOTTOM;
    end else begin
      side_next = sitc_pkg::SIDE_RIGHT;
    end
  end

  assign adve = !ve || advf;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (adve) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adve && vd) begin
      side_q <= side_next;
      d16_q  <= d_q[SW-1:0];
      k_e    <= k_q;
      k3_q   <= {k_q[SW-2:0], 1'b0} + k_q;
      k5_q   <= {k_q[SW-3:0], 2'b00} + k_q;
      k7_q   <= {k_q[SW-4:0], 3'b000} - k_q;
      tag_e  <= tag_d;
    end
  end

  // output stage: coordinates, all arithmetic modulo the field width
  logic [SW-1:0] line_next;
  logic [SW-1:0] column_next;
  logic          bad_next;
  logic          vf;

  always_comb begin
    case (side_q)
      sitc_pkg::SIDE_TOP: begin
        line_next   = tag_e.c1 + k_e;
        column_next = tag_e.c1 + k_e - d16_q;
      end
      sitc_pkg::SIDE_LEFT: begin
        line_next   = tag_e.c1 + k3_q - d16_q;
        column_next = tag_e.c1 - k_e;
      end
      sitc_pkg::SIDE_BOTTOM: begin
        line_next   = tag_e.c1 - k_e;
        column_next = tag_e.c1 - k5_q + d16_q;
      end
      sitc_pkg::SIDE_RIGHT: begin
        line_next   = tag_e.c1 - k7_q + d16_q;
        column_next = tag_e.c1 + k_e;
      end
      default: begin
        line_next   = '0;
        column_next = '0;
      end
    endcase
    bad_next = 1'b0;
    if (tag_e.one) begin
      line_next   = SW'(1);
      column_next = SW'(1);
    end else if (tag_e.bad) begin
      line_next   = '0;
      column_next = '0;
      bad_next    = 1'b1;
    end else if (tag_e.pos_one) begin
      // centre cell
      line_next   = tag_e.c1;
      column_next = tag_e.c1;
    end
  end

  assign advf      = !vf || out_ready;
  assign out_valid = vf;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (advf) begin
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (advf && ve) begin
      line         <= line_next;
      column       <= column_next;
      position_bad <= bad_next;
    end
  end

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    vf && position_bad |-> line == '0 && column == '0)
    else $error("flagged beat carries nonzero coordinates");

  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    vf && !position_bad |-> line != '0 && column != '0)
    else $error("placed beat has a zero coordinate");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    vd && !tag_d.one && !tag_d.bad && !tag_d.pos_one
      |-> d_q != '0 && {1'b0, d_q} <= {k_q, 3'b000})
    else $error("ring offset outside one to eight times the ring");
`endif

endmodule

@@ tb/sv/spiral_index_to_coordinate_monitor.sv @@
// watches both channels, predicts each spiral coordinate beat and compares it
module spiral_index_to_coordinate_monitor
  import sitc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIDE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [POS_W-1:0]  position,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [SIDE_W-1:0] line,
  input  logic [SIDE_W-1:0] column,
  input  logic              position_bad,
  output int                fails,
  output int                pending
);

  typedef struct packed {
    logic [SIDE_W-1:0] line;
    logic [SIDE_W-1:0] column;
    logic              bad;
  } place_t;

  logic [SIDE_W-1:0] side_q;
  place_t            coord_fifo[$];

  function automatic place_t spiral_place(input logic [SIDE_W-1:0] side,
                                          input logic [POS_W-1:0] pos);
    place_t     res;
    longint     n, p, ctr, row, col, rt, t, ring, off;
    int         b;
    ring_side_t which;
    res = '0;
    n   = side;
    p   = pos;
    if (n == 1) begin
      res.line   = SIDE_W'(1);
      res.column = SIDE_W'(1);
      return res;
    end
    if (n % 2 == 0 || p == 0 || p > n * n) begin
      res.bad = 1'b1;
      return res;
    end
    // rows counted from the top here, flipped at the end
    ctr = (n - 1) / 2;
    if (p == 1) begin
      row = ctr;
      col = ctr;
    end else begin
      rt = 0;
      for (b = 15; b >= 0; b--) begin
        t = rt + (longint'(1) << b);
        if (t * t <= p - 1) rt = t;
      end
      if (rt % 2 == 0) rt = rt - 1;
      ring = (rt + 1) / 2;
      off  = p - rt * rt;
      // the first step past the inner corner already sits on the top side
      if (off <= 2 * ring) which = SIDE_TOP;
      else if (off <= 4 * ring) which = SIDE_LEFT;
      else if (off <= 6 * ring) which = SIDE_BOTTOM;
      else which = SIDE_RIGHT;
      case (which)
        SIDE_TOP: begin
          row = ctr - ring;
          col = ctr + ring - off;
        end
        SIDE_LEFT: begin
          row = ctr - ring + (off - 2 * ring);
          col = ctr - ring;
        end
        SIDE_BOTTOM: begin
          row = ctr + ring;
          col = ctr - ring + (off - 4 * ring);
        end
        default: begin
          row = ctr + ring - (off - 6 * ring);
          col = ctr + ring;
        end
      endcase
    end
    res.line   = SIDE_W'(n - row);
    res.column = SIDE_W'(col + 1);
    return res;
  endfunction

  initial begin
    fails   = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    place_t exp_place;
    if (rst) begin
      side_q <= SIDE_W'(1);
      coord_fifo.delete();
    end else begin
      // retire before queueing so a stray result beat never meets a fresh entry
      if (out_valid && out_ready) begin
        if (coord_fifo.size() == 0) begin
          if (fails < 10)
            $display("unexpected result beat: line %0d column %0d bad %0b",
                     line, column, position_bad);
          fails++;
        end else begin
          exp_place = coord_fifo.pop_front();
          if (line !== exp_place.line || column !== exp_place.column ||
              position_bad !== exp_place.bad) begin
            if (fails < 10)
              $display("mismatch: line %0d/%0d column %0d/%0d bad %0b/%0b (exp/got)",
                       exp_place.line, line, exp_place.column, column,
                       exp_place.bad, position_bad);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) coord_fifo = {coord_fifo, spiral_place(side_q, position)};
      if (cfg_wr_en) side_q <= cfg_wr_data;
    end
    pending = coord_fifo.size();
  end

endmodule

@@ tb/sv/spiral_index_to_coordinate_top_tb.sv @@
// stimulus, clock and verdict for the spiral coordinate block
module spiral_index_to_coordinate_top_tb;
  import sitc_pkg::*;

  localparam int DRAIN = 24;
  localparam int LIMIT = 500000;
  localparam int LONG_HOLD = 400;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [SIDE_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [POS_W-1:0]  position;
  logic              out_valid;
  logic              out_ready;
  logic [SIDE_W-1:0] line;
  logic [SIDE_W-1:0] column;
  logic              position_bad;

  int fails;
  int pending;
  int sent;
  int cycles;

  spiral_index_to_coordinate_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line         (line),
    .column       (column),
    .position_bad (position_bad)
  );

  spiral_index_to_coordinate_monitor u_mon (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line         (line),
    .column       (column),
    .position_bad (position_bad),
    .fails        (fails),
    .pending      (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("spiral_index_to_coordinate_top test failed");
      $finish;
    end
  end

  // mostly positions on the grid, with ring corners, zero and overshoot mixed in
  function automatic logic [POS_W-1:0] pick_position(input logic [SIDE_W-1:0] side);
    longint lim, rings, k, m;
    int     sel;
    lim   = longint'(side) * longint'(side);
    rings = (longint'(side) - 1) / 2;
    sel   = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 16) return $urandom;
    if (sel < 24 && lim < 64'hFFFF_FFF0) return POS_W'(lim + $urandom_range(1, 15));
    if (lim == 0) return $urandom;
    if (sel < 40) return POS_W'($urandom_range(1, (lim < 60) ? 32'(lim) : 60));
    if (sel < 60 && rings > 0) begin
      k = $urandom_range(1, 32'(rings));
      m = 2 * k - 1;
      return POS_W'(m * m + 2 * k * $urandom_range(0, 3) + $urandom_range(0, 1));
    end
    return $urandom_range(1, 32'(lim));
  endfunction

  task automatic send_pos(input logic [POS_W-1:0] p);
    int gap;
    gap = (((sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  // side changes only once every beat in flight has come back
  task automatic set_side(input logic [SIDE_W-1:0] s);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : receiver
    int w;
    int beats;
    out_ready = 1'b0;
    beats     = 0;
    @(negedge clk iff !rst);
    forever begin
      w = (((beats / 50) % 4) == 1) ? 0 : $urandom_range(0, 15);
      // one long hold so the pipeline fills and backs up into the input
      if (beats == 300) w = LONG_HOLD;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      beats++;
    end
  end

  initial begin : stimulus
    logic [SIDE_W-1:0] side_plan[10];
    int                ph;
    int                i;
    int                p;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    position    = '0;
    sent        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset side of one maps everything to the single cell
    send_pos('0);
    send_pos(POS_W'(1));
    send_pos('1);
    // side three walks zero, the whole ring and one step past it
    set_side(SIDE_W'(3));
    for (p = 0; p <= 10; p++) send_pos(POS_W'(p));
    set_side('0);
    send_pos(POS_W'(1));
    set_side('1);
    send_pos(POS_W'(32'd4294836225));
    send_pos(POS_W'(32'd4294836226));
    send_pos('1);
    send_pos(POS_W'(1));
    set_side(SIDE_W'(2));
    send_pos(POS_W'(1));

    side_plan[0] = SIDE_W'(7);
    side_plan[1] = '1;
    side_plan[2] = '0;
    side_plan[3] = SIDE_W'(1);
    side_plan[4] = SIDE_W'($urandom_range(4, 127) * 2 + 1);
    side_plan[5] = SIDE_W'(65534);
    side_plan[6] = SIDE_W'($urandom_range(128, 32766) * 2 + 1);
    side_plan[7] = SIDE_W'(65533);
    side_plan[8] = SIDE_W'(2);
    side_plan[9] = SIDE_W'(15);
    for (ph = 0; ph < 10; ph++) begin
      set_side(side_plan[ph]);
      for (i = 0; i < 65; i++) send_pos(pick_position(side_plan[ph]));
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fails == 0) begin
      $display("spiral_index_to_coordinate_top test passed");
    end else begin
      $display("spiral_index_to_coordinate_top test failed");
    end
    $finish;
  end

endmodule
